[rtl/w3s_pkg.sv]
// Shared types and constants of the 3x3 window sum and extremes block.
package w3s_pkg;

   // Field widths of the pixel stream and of the result.
   localparam int PIXEL_W   = 8;
   localparam int COL_SUM_W = PIXEL_W + 2;
   localparam int SUM_W     = 12;
   localparam int POS_W     = 8;
   localparam int CFG_W     = 9;
   localparam int CSR_IDX_W = 1;
   localparam int RSP_W     = 2 * SUM_W + 4 * POS_W;

   // Value above any window sum; the running minimum starts here.
   localparam logic [SUM_W-1:0] SUM_ABOVE_ALL = SUM_W'(9 * ((1 << PIXEL_W) - 1) + 1);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COLS = 1'b1;

   // One classified column handed from the front end to the back end.
   typedef struct packed {
      logic [COL_SUM_W-1:0] col_sum;
      logic                 win_valid;
      logic                 frame_end;
      logic [POS_W-1:0]     row;
      logic [POS_W-1:0]     col;
   } w3s_col_type;

   // Result word; the first field sits in the highest bits.
   typedef struct packed {
      logic [POS_W-1:0] min_col;
      logic [POS_W-1:0] min_row;
      logic [SUM_W-1:0] min_sum;
      logic [POS_W-1:0] max_col;
      logic [POS_W-1:0] max_row;
      logic [SUM_W-1:0] max_sum;
   } w3s_result_type;

endpackage

[rtl/w3s_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module w3s_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/w3s_front.sv]
// Front end: pixel acceptance, frame counters, line buffers and column sums.
module w3s_front #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [w3s_pkg::PIXEL_W-1:0]      req_pixel,
   input  logic                             csr_valid,
   input  logic [w3s_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [w3s_pkg::CFG_W-1:0]        csr_data,
   output logic                             col_valid,
   input  logic                             col_ready,
   output w3s_pkg::w3s_col_type             col_data
);
   import w3s_pkg::*;

   localparam int CW = $clog2(MAX_COLS);
   localparam int RW = $clog2(MAX_ROWS);

   // Clamped frame size, held as the index of the last row and column.
   logic [RW-1:0] rows_last_ff, rows_last_in;
   logic [CW-1:0] cols_last_ff, cols_last_in;

   // Position of the next pixel.
   logic [RW-1:0] row_count_ff, row_count_in;
   logic [CW-1:0] col_count_ff, col_count_in;

   // Stage holding an accepted pixel while its line-buffer read returns.
   logic              s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0] s1_pix_ff;
   logic [CW-1:0]     s1_addr_ff;
   logic              s1_win_ff;
   logic              s1_end_ff;
   logic [POS_W-1:0]  s1_row_ff;
   logic [POS_W-1:0]  s1_col_ff;

   logic                 req_accept;
   logic                 col_push;
   logic                 row_end;
   logic                 frame_end;
   logic                 win_valid;
   logic [2*PIXEL_W-1:0] lb_rd_data;
   logic [PIXEL_W-1:0]   lb_upper;
   logic [PIXEL_W-1:0]   lb_middle;

   assign col_push   = s1_valid_ff && col_ready;
   assign req_tready = !s1_valid_ff || col_ready;
   assign req_accept = req_tvalid && req_tready;

   // Clamp of written frame sizes to the supported range.
   always_comb begin
      rows_last_in = rows_last_ff;
      cols_last_in = cols_last_ff;
      if (csr_valid && csr_index == CSR_FRAME_ROWS) begin
         if (csr_data < CFG_W'(3)) begin
            rows_last_in = RW'(2);
         end else if (32'(csr_data) > 32'(MAX_ROWS)) begin
            rows_last_in = RW'(MAX_ROWS - 1);
         end else begin
            rows_last_in = RW'(csr_data - CFG_W'(1));
         end
      end
      if (csr_valid && csr_index == CSR_FRAME_COLS) begin
         if (csr_data < CFG_W'(3)) begin
            cols_last_in = CW'(2);
         end else if (32'(csr_data) > 32'(MAX_COLS)) begin
            cols_last_in = CW'(MAX_COLS - 1);
         end else begin
            cols_last_in = CW'(csr_data - CFG_W'(1));
         end
      end
   end

   // Classification of the pixel and advance of the counters.
   assign row_end   = col_count_ff >= cols_last_ff;
   assign frame_end = row_end && (row_count_ff >= rows_last_ff);
   assign win_valid = (32'(row_count_ff) >= 32'd2) && (32'(col_count_ff) >= 32'd2);

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (req_accept) begin
         if (!row_end) begin
            col_count_in = col_count_ff + CW'(1);
         end else if (!frame_end) begin
            col_count_in = '0;
            row_count_in = row_count_ff + RW'(1);
         end else begin
            col_count_in = '0;
            row_count_in = '0;
         end
      end
   end

   assign s1_valid_in = req_accept || (s1_valid_ff && !col_ready);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_last_ff <= RW'(2);
         cols_last_ff <= CW'(2);
         row_count_ff <= '0;
         col_count_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         rows_last_ff <= rows_last_in;
         cols_last_ff <= cols_last_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   // Payload of the read stage.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pix_ff  <= req_pixel;
         s1_addr_ff <= col_count_ff;
         s1_win_ff  <= win_valid;
         s1_end_ff  <= frame_end;
         s1_row_ff  <= POS_W'(32'(row_count_ff) - 32'd2);
         s1_col_ff  <= POS_W'(32'(col_count_ff) - 32'd2);
      end
   end

   // Both line buffers share one word: the middle row above the upper row.
   w3s_ram #(
      .WIDTH (2 * PIXEL_W),
      .DEPTH (MAX_COLS)
   ) u_line_buffers (
      .clock   (clock),
      .wr_en   (col_push),
      .wr_addr (s1_addr_ff),
      .wr_data ({s1_pix_ff, lb_middle}),
      .rd_en   (req_accept),
      .rd_addr (col_count_ff),
      .rd_data (lb_rd_data)
   );

   assign lb_upper  = lb_rd_data[PIXEL_W-1:0];
   assign lb_middle = lb_rd_data[2*PIXEL_W-1:PIXEL_W];

   // Column sum of the three rows and hand-over to the queue.
   assign col_valid         = s1_valid_ff;
   assign col_data.col_sum  = COL_SUM_W'(lb_upper) + COL_SUM_W'(lb_middle)
                            + COL_SUM_W'(s1_pix_ff);
   assign col_data.win_valid = s1_win_ff;
   assign col_data.frame_end = s1_end_ff;
   assign col_data.row       = s1_row_ff;
   assign col_data.col       = s1_col_ff;

endmodule

[rtl/w3s_queue.sv]
// Two-entry queue that decouples the front end from the back end.
module w3s_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  w3s_pkg::w3s_col_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output w3s_pkg::w3s_col_type pop_data
);
   import w3s_pkg::*;

   w3s_col_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   logic        pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/w3s_back.sv]
// Back end: window sums, running extremes and the result register.
module w3s_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    col_valid,
   output logic                    col_ready,
   input  w3s_pkg::w3s_col_type    col_data,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output w3s_pkg::w3s_result_type rsp_result
);
   import w3s_pkg::*;

   // Column sums of the two previous columns.
   logic [COL_SUM_W-1:0] cs_prev_ff;
   logic [COL_SUM_W-1:0] cs_prev2_ff;

   // Running extremes of the current frame.
   logic [SUM_W-1:0] best_max_ff, best_max_in;
   logic [POS_W-1:0] max_row_ff, max_row_in;
   logic [POS_W-1:0] max_col_ff, max_col_in;
   logic [SUM_W-1:0] best_min_ff, best_min_in;
   logic [POS_W-1:0] min_row_ff, min_row_in;
   logic [POS_W-1:0] min_col_ff, min_col_in;

   logic           rsp_valid_ff, rsp_valid_in;
   w3s_result_type rsp_result_ff;
   w3s_result_type frame_result;

   logic             out_free;
   logic             pop;
   logic [SUM_W-1:0] win_sum;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign col_ready = !col_data.frame_end || out_free;
   assign pop       = col_valid && col_ready;
   assign win_sum   = SUM_W'(cs_prev2_ff) + SUM_W'(cs_prev_ff) + SUM_W'(col_data.col_sum);

   // Strict compares, so the first window in raster order keeps a tie.
   always_comb begin
      best_max_in = best_max_ff;
      max_row_in  = max_row_ff;
      max_col_in  = max_col_ff;
      best_min_in = best_min_ff;
      min_row_in  = min_row_ff;
      min_col_in  = min_col_ff;
      if (col_data.win_valid && win_sum > best_max_ff) begin
         best_max_in = win_sum;
         max_row_in  = col_data.row;
         max_col_in  = col_data.col;
      end
      if (col_data.win_valid && win_sum < best_min_ff) begin
         best_min_in = win_sum;
         min_row_in  = col_data.row;
         min_col_in  = col_data.col;
      end
      frame_result.max_sum = best_max_in;
      frame_result.max_row = max_row_in;
      frame_result.max_col = max_col_in;
      frame_result.min_sum = best_min_in;
      frame_result.min_row = min_row_in;
      frame_result.min_col = min_col_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (pop && col_data.frame_end) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Extremes restart after each frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         best_max_ff  <= '0;
         max_row_ff   <= '0;
         max_col_ff   <= '0;
         best_min_ff  <= SUM_ABOVE_ALL;
         min_row_ff   <= '0;
         min_col_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop && col_data.frame_end) begin
            best_max_ff <= '0;
            max_row_ff  <= '0;
            max_col_ff  <= '0;
            best_min_ff <= SUM_ABOVE_ALL;
            min_row_ff  <= '0;
            min_col_ff  <= '0;
         end else if (pop) begin
            best_max_ff <= best_max_in;
            max_row_ff  <= max_row_in;
            max_col_ff  <= max_col_in;
            best_min_ff <= best_min_in;
            min_row_ff  <= min_row_in;
            min_col_ff  <= min_col_in;
         end
      end
   end

   // Window column shift and result payload.
   always_ff @(posedge clock) begin
      if (pop) begin
         cs_prev2_ff <= cs_prev_ff;
         cs_prev_ff  <= col_data.col_sum;
      end
      if (pop && col_data.frame_end) begin
         rsp_result_ff <= frame_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule

[rtl/window3x3_sum_extremes.sv]
// A frame's result passes the line-buffer read stage, the queue
// and the result register. Throughput: one pixel per cycle, set by the single
// line-buffer RAM port pair, while the queue and the result path take columns.
// The result register frees the pixel path while a result waits to be taken.
// Reset clears counters, extremes, the queue and sets the frame size to 3 by 3;
// line buffers are not cleared and need no clearing pass.
module window3x3_sum_extremes #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   // Pixel stream.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // pixel[7:0]
   // Configuration writes.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [w3s_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [w3s_pkg::CFG_W-1:0]     csr_data,
   // Result stream.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // max_sum[11:0], max_row[19:12], max_col[27:20],
   // min_sum[39:28], min_row[47:40], min_col[55:48]
   output logic [55:0]                   rsp_tdata
);
   import w3s_pkg::*;

   logic           front_valid;
   logic           front_ready;
   w3s_col_type    front_data;
   logic           back_valid;
   logic           back_ready;
   w3s_col_type    back_data;
   w3s_result_type rsp_result;

   // Configuration writes are taken in every cycle.
   assign csr_ready = 1'b1;

   w3s_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_pixel  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .col_valid  (front_valid),
      .col_ready  (front_ready),
      .col_data   (front_data)
   );

   w3s_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_data),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_data)
   );

   w3s_back u_back (
      .clock      (clock),
      .reset      (reset),
      .col_valid  (back_valid),
      .col_ready  (back_ready),
      .col_data   (back_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = rsp_result;

endmodule
